/* design/pidc_pkg.sv */
// ----------------------------------------------------------------------------
// pidc_pkg: shared types and microcode for the PID controller
// Data formats, control word layout, register indexes and the step program.
// ----------------------------------------------------------------------------
package pidc_pkg;

    localparam int DATA_W    = 32;   // signed data word, Q16.16
    localparam int COEF_W    = 32;   // unsigned gain / time word
    localparam int FRAC_BITS = 16;
    localparam int OLIM_W    = 31;
    localparam int PROD_W    = DATA_W + COEF_W;
    localparam int CFG_IDX_W = 3;

    localparam logic [OLIM_W-1:0] OLIM_RESET = 31'd6553600;  // 100.0

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PROP_GAIN  = 3'd0,
        REG_INTEG_GAIN = 3'd1,
        REG_DERIV_GAIN = 3'd2,
        REG_OUT_LIMIT  = 3'd3,
        REG_TIME_STEP  = 3'd4,
        REG_INV_STEP   = 3'd5
    } t_cfg_idx;

    // datapath operation of one step
    typedef enum logic [2:0] {
        OP_NONE,
        OP_ERR,     // error = sat(setpoint - measurement), clear accumulator
        OP_DIFF,    // diff = sat(error - last error)
        OP_INTEG,   // integral = clamp(sat(integral + term))
        OP_ACC,     // accumulator += term
        OP_FINAL,   // drive = clamp(sat(accumulator)), emit word
        OP_CLEAR    // zero state, emit zero word
    } t_op;

    typedef enum logic [1:0] {
        A_ERR,
        A_DIFF,
        A_INTEG,
        A_DERIV
    } t_asel;

    typedef enum logic [2:0] {
        B_TIME_STEP,
        B_INV_STEP,
        B_PROP,
        B_INTEG,
        B_DERIV
    } t_bsel;

    typedef logic [3:0] t_pc;

    localparam t_pc STEP_FIRST = 4'd0;
    localparam t_pc STEP_CLEAR = 4'd9;

    typedef struct packed {
        logic mul_en;   // register |a| * b
        logic rnd_en;   // round and saturate the held product into term
    } t_mul_ctrl;

    typedef struct packed {
        t_op       op;
        t_asel     a_sel;
        t_bsel     b_sel;
        t_mul_ctrl mul;
        logic      jmp_clr;  // jump to target when the word is a clear
        t_pc       target;
        logic      last;     // final step, emits the result
    } t_ctrl_word;

    localparam t_mul_ctrl MC_NONE = '{mul_en: 1'b0, rnd_en: 1'b0};
    localparam t_mul_ctrl MC_MUL  = '{mul_en: 1'b1, rnd_en: 1'b0};
    localparam t_mul_ctrl MC_RND  = '{mul_en: 1'b0, rnd_en: 1'b1};
    localparam t_mul_ctrl MC_BOTH = '{mul_en: 1'b1, rnd_en: 1'b1};

    // Step program. Product issued at step n is rounded at n+1 and used at n+2.
    function automatic t_ctrl_word f_ucode(input t_pc pc);
        t_ctrl_word w;
        w = '{op: OP_NONE, a_sel: A_ERR, b_sel: B_TIME_STEP, mul: MC_NONE,
              jmp_clr: 1'b0, target: STEP_FIRST, last: 1'b0};
        case (pc)
            4'd0: begin
                w.op      = OP_ERR;
                w.jmp_clr = 1'b1;
                w.target  = STEP_CLEAR;
            end
            4'd1: begin
                w.op = OP_DIFF;  w.mul = MC_MUL;
                w.a_sel = A_ERR; w.b_sel = B_TIME_STEP;
            end
            4'd2: begin
                w.mul = MC_BOTH;
                w.a_sel = A_ERR; w.b_sel = B_PROP;
            end
            4'd3: begin
                w.op = OP_INTEG;  w.mul = MC_BOTH;
                w.a_sel = A_DIFF; w.b_sel = B_INV_STEP;
            end
            4'd4: begin
                w.op = OP_ACC;     w.mul = MC_BOTH;
                w.a_sel = A_INTEG; w.b_sel = B_INTEG;
            end
            4'd5: begin
                w.mul = MC_BOTH;
                w.a_sel = A_DERIV; w.b_sel = B_DERIV;
            end
            4'd6: begin
                w.op = OP_ACC; w.mul = MC_RND;
            end
            4'd7: begin
                w.op = OP_ACC;
            end
            4'd8: begin
                w.op = OP_FINAL; w.last = 1'b1;
            end
            4'd9: begin
                w.op = OP_CLEAR; w.last = 1'b1;
            end
            default: begin
                w.op = OP_NONE;
            end
        endcase
        return w;
    endfunction

endpackage

/* design/pidc_mulq.sv */
// ----------------------------------------------------------------------------
// pidc_mulq: shared fixed-point multiplier
// Signed data times unsigned coefficient, magnitude rounded half away from
// zero at FRAC_BITS, saturated to the data word. Two register stages.
// ----------------------------------------------------------------------------
module pidc_mulq (
    input  logic                              i_clk,
    input  pidc_pkg::t_mul_ctrl               i_ctrl,
    input  logic signed [pidc_pkg::DATA_W-1:0] i_a,
    input  logic        [pidc_pkg::COEF_W-1:0] i_b,
    output logic signed [pidc_pkg::DATA_W-1:0] o_term
);
    import pidc_pkg::*;

    localparam logic [PROD_W-1:0] RND     = PROD_W'(1) << (FRAC_BITS - 1);
    localparam logic [PROD_W-1:0] LIM_POS = PROD_W'((64'd1 << (DATA_W - 1)) - 64'd1);
    localparam logic [PROD_W-1:0] LIM_NEG = PROD_W'(64'd1 << (DATA_W - 1));

    logic [PROD_W-1:0]        r_prod;
    logic                     r_neg;
    logic signed [DATA_W-1:0] r_term;

    logic [DATA_W-1:0] w_mag_a;
    logic [PROD_W-1:0] w_rnd;
    logic [PROD_W-1:0] w_mag;
    logic [PROD_W-1:0] w_lim;
    logic [DATA_W-1:0] w_sat;

    // |a| fits the unsigned word, including the most negative value
    assign w_mag_a = i_a[DATA_W-1] ? (DATA_W'(0) - DATA_W'(i_a)) : DATA_W'(i_a);

    // product < 2^63, so the rounding add cannot carry out
    assign w_rnd = r_prod + RND;
    assign w_mag = w_rnd >> FRAC_BITS;
    assign w_lim = r_neg ? LIM_NEG : LIM_POS;
    assign w_sat = (w_mag > w_lim) ? w_lim[DATA_W-1:0] : w_mag[DATA_W-1:0];

    always_ff @(posedge i_clk) begin
        if (i_ctrl.mul_en) begin
            r_prod <= PROD_W'(w_mag_a) * PROD_W'(i_b);
            r_neg  <= i_a[DATA_W-1];
        end
        if (i_ctrl.rnd_en) begin
            r_term <= r_neg ? signed'(DATA_W'(0) - w_sat) : signed'(w_sat);
        end
    end

    assign o_term = r_term;

endmodule

/* design/pid_controller_antiwindup_top.sv */
// ----------------------------------------------------------------------------
// pid_controller_antiwindup_top: PID controller with integral clamp
// Microcoded sequencer over one shared multiplier; Q16.16 fixed point.
// ----------------------------------------------------------------------------
// Usage
//   Input stream (s_axis): one word per control step. tdata holds setpoint
//   (bits 31:0) and measurement (bits 63:32), both signed Q16.16. tuser is
//   the command: 0 compute a step, 1 clear integral and previous error.
//   Output stream (m_axis): one word per input word. tdata is the drive,
//   signed Q16.16; tuser bit 0 flags output clamping, bit 1 integral clamping.
//   Clear words return drive 0 with both flags low.
//   Config port: write gains, output limit, time step and reciprocal by index
//   whenever no word is in flight; writes to unused indexes are dropped.
// Timing
//   A compute word runs a 9-step program and a clear word takes 2 steps; the
//   next word is taken only once the program has finished its final step.
//   The step count is set by the five products sharing one 32x32 multiplier,
//   each needing a multiply step and a round step before use.
// Reset and backpressure
//   Synchronous active-low reset loads register defaults (output limit 100.0)
//   and zeroes the integral and previous error. The result sits in an output
//   register; a new word is accepted while it waits, and the program holds on
//   its final step until that register frees up.
// ----------------------------------------------------------------------------
module pid_controller_antiwindup_top (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // configuration
    input  logic                               i_cfg_we,
    input  logic [pidc_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [pidc_pkg::COEF_W-1:0]        i_cfg_data,
    // input stream
    input  logic                               i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    input  logic [2*pidc_pkg::DATA_W-1:0]      i_s_axis_tdata,   // setpoint, measurement
    input  logic                               i_s_axis_tuser,   // cmd
    // output stream
    output logic                               o_m_axis_tvalid,
    input  logic                               i_m_axis_tready,
    output logic [pidc_pkg::DATA_W-1:0]        o_m_axis_tdata,   // drive
    output logic [1:0]                         o_m_axis_tuser    // output_clamped, integral_clamped
);
    import pidc_pkg::*;

    localparam logic signed [DATA_W+1:0] DMAX34 = (DATA_W+2)'((64'd1 << (DATA_W - 1)) - 64'd1);
    localparam logic signed [DATA_W+1:0] DMIN34 = -DMAX34 - (DATA_W+2)'(1);

    // configuration registers
    logic [COEF_W-1:0] r_kp, r_ki, r_kd, r_ts, r_inv;
    logic [OLIM_W-1:0] r_olim;

    // sequencer
    logic       r_busy;
    t_pc        r_pc;
    t_ctrl_word w_cw;
    logic       w_stall;
    logic       w_exec;

    // captured input word
    logic                     r_cmd;
    logic signed [DATA_W-1:0] r_sp, r_ms;

    // datapath
    logic signed [DATA_W-1:0] r_err, r_diff, r_ei, r_last;
    logic signed [DATA_W+1:0] r_acc;
    logic                     r_ic;
    logic signed [DATA_W-1:0] w_term;
    logic signed [DATA_W-1:0] w_a;
    logic        [COEF_W-1:0] w_b;

    // output register
    logic                     r_m_valid;
    logic signed [DATA_W-1:0] r_drive;
    logic                     r_oc, r_ic_out;

    // saturate a 33-bit signed value: {hit, value}
    function automatic logic [DATA_W:0] f_sat33(input logic signed [DATA_W:0] v);
        logic [DATA_W:0] res;
        if (v[DATA_W] != v[DATA_W-1]) begin
            res = {1'b1, v[DATA_W], {(DATA_W-1){~v[DATA_W]}}};
        end else begin
            res = {1'b0, v[DATA_W-1:0]};
        end
        return res;
    endfunction

    assign w_cw    = f_ucode(r_pc);
    assign w_stall = w_cw.last && r_m_valid && !i_m_axis_tready;
    assign w_exec  = r_busy && !w_stall;

    assign o_s_axis_tready = !r_busy;

    // ---- configuration ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kp   <= '0;
            r_ki   <= '0;
            r_kd   <= '0;
            r_olim <= OLIM_RESET;
            r_ts   <= '0;
            r_inv  <= '0;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                REG_PROP_GAIN:  r_kp   <= i_cfg_data;
                REG_INTEG_GAIN: r_ki   <= i_cfg_data;
                REG_DERIV_GAIN: r_kd   <= i_cfg_data;
                REG_OUT_LIMIT:  r_olim <= i_cfg_data[OLIM_W-1:0];
                REG_TIME_STEP:  r_ts   <= i_cfg_data;
                REG_INV_STEP:   r_inv  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // ---- step counter ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_pc   <= STEP_FIRST;
        end else if (!r_busy) begin
            if (i_s_axis_tvalid) begin
                r_busy <= 1'b1;
                r_pc   <= STEP_FIRST;
            end
        end else if (!w_stall) begin
            if (w_cw.last) begin
                r_busy <= 1'b0;
            end else if (w_cw.jmp_clr && r_cmd) begin
                r_pc <= w_cw.target;
            end else begin
                r_pc <= r_pc + t_pc'(1);
            end
        end
    end

    // input capture, no reset needed
    always_ff @(posedge i_clk) begin
        if (i_s_axis_tvalid && !r_busy) begin
            r_cmd <= i_s_axis_tuser;
            r_sp  <= signed'(i_s_axis_tdata[DATA_W-1:0]);
            r_ms  <= signed'(i_s_axis_tdata[2*DATA_W-1:DATA_W]);
        end
    end

    // ---- shared multiplier ----
    always_comb begin
        case (w_cw.a_sel)
            A_ERR:   w_a = r_err;
            A_DIFF:  w_a = r_diff;
            A_INTEG: w_a = r_ei;
            A_DERIV: w_a = (r_ts == '0) ? '0 : w_term;  // derivative off at zero step
            default: w_a = '0;
        endcase
        case (w_cw.b_sel)
            B_TIME_STEP: w_b = r_ts;
            B_INV_STEP:  w_b = r_inv;
            B_PROP:      w_b = r_kp;
            B_INTEG:     w_b = r_ki;
            B_DERIV:     w_b = r_kd;
            default:     w_b = '0;
        endcase
    end

    pidc_mulq u_mulq (
        .i_clk  (i_clk),
        .i_ctrl (w_exec ? w_cw.mul : MC_NONE),
        .i_a    (w_a),
        .i_b    (w_b),
        .o_term (w_term)
    );

    // ---- datapath ops ----
    logic [DATA_W:0]          w_err_s, w_diff_s, w_int_s;
    logic signed [DATA_W:0]   w_ilim, w_int_v;
    logic signed [DATA_W+1:0] w_olim, w_sum;
    logic                     w_int_hit;
    logic                     w_out_hit;

    assign w_err_s  = f_sat33((DATA_W+1)'(r_sp) - (DATA_W+1)'(r_ms));
    assign w_diff_s = f_sat33((DATA_W+1)'(r_err) - (DATA_W+1)'(r_last));
    assign w_int_s  = f_sat33((DATA_W+1)'(r_ei) + (DATA_W+1)'(w_term));
    assign w_ilim   = signed'((DATA_W+1)'(r_olim[OLIM_W-1:1]));
    assign w_olim   = signed'((DATA_W+2)'(r_olim));

    // integral: word saturation, then half-limit clamp
    always_comb begin
        w_int_v   = signed'({w_int_s[DATA_W-1], w_int_s[DATA_W-1:0]});
        w_int_hit = w_int_s[DATA_W];
        if (w_int_v > w_ilim) begin
            w_int_v   = w_ilim;
            w_int_hit = 1'b1;
        end else if (w_int_v < -w_ilim) begin
            w_int_v   = -w_ilim;
            w_int_hit = 1'b1;
        end
    end

    // output: exact sum saturated once, then limit clamp
    always_comb begin
        w_sum     = r_acc;
        w_out_hit = 1'b0;
        if (w_sum > DMAX34) begin
            w_sum     = DMAX34;
            w_out_hit = 1'b1;
        end else if (w_sum < DMIN34) begin
            w_sum     = DMIN34;
            w_out_hit = 1'b1;
        end
        if (w_sum > w_olim) begin
            w_sum     = w_olim;
            w_out_hit = 1'b1;
        end else if (w_sum < -w_olim) begin
            w_sum     = -w_olim;
            w_out_hit = 1'b1;
        end
    end

    // state held across words
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ei   <= '0;
            r_last <= '0;
        end else if (w_exec) begin
            case (w_cw.op)
                OP_INTEG: r_ei   <= w_int_v[DATA_W-1:0];
                OP_FINAL: r_last <= r_err;
                OP_CLEAR: begin
                    r_ei   <= '0;
                    r_last <= '0;
                end
                default: ;
            endcase
        end
    end

    // per-word scratch
    always_ff @(posedge i_clk) begin
        if (w_exec) begin
            case (w_cw.op)
                OP_ERR: begin
                    r_err <= signed'(w_err_s[DATA_W-1:0]);
                    r_acc <= '0;
                end
                OP_DIFF:  r_diff <= signed'(w_diff_s[DATA_W-1:0]);
                OP_INTEG: r_ic   <= w_int_hit;
                OP_ACC:   r_acc  <= r_acc + (DATA_W+2)'(w_term);
                default: ;
            endcase
        end
    end

    // ---- output register ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (w_exec && w_cw.last) begin
            r_m_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_exec && w_cw.last) begin
            if (w_cw.op == OP_FINAL) begin
                r_drive  <= w_sum[DATA_W-1:0];
                r_oc     <= w_out_hit;
                r_ic_out <= r_ic;
            end else begin
                r_drive  <= '0;
                r_oc     <= 1'b0;
                r_ic_out <= 1'b0;
            end
        end
    end

    assign o_m_axis_tvalid = r_m_valid;
    assign o_m_axis_tdata  = r_drive;
    assign o_m_axis_tuser  = {r_ic_out, r_oc};

    // ---- assertions ----
    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> (r_busy && r_pc == STEP_FIRST))
        else $error("accepted word did not start the program");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && w_stall) |=> (r_busy && $stable(r_pc) && o_m_axis_tvalid))
        else $error("program advanced over an occupied output register");

    a_clear_zeroes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_exec && w_cw.op == OP_CLEAR) |=>
            (r_ei == '0 && r_last == '0 && o_m_axis_tvalid && o_m_axis_tdata == '0))
        else $error("clear word left state or output nonzero");

    a_single_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_exec && w_cw.last) |=> !r_busy)
        else $error("sequencer still busy after final step");

endmodule
